/* hw/rtl/devr_pkg.sv */
`timescale 1ns / 1ps
package devr_pkg;

    // field widths
    localparam int RDW = 25;               // reading / offset / tolerance
    localparam int RCW = 32;               // reciprocal ratio, Q8.24
    localparam int OW  = 48;               // output position, Q31.16
    localparam int PW  = 50;               // internal position width
    localparam int MW  = PW - 1;           // magnitude fed to the remainder unit
    localparam int SW  = 33;               // step width
    localparam int PRW = RDW + RCW;        // base product width
    localparam int RW  = PRW + 1 - 24;     // rounded base magnitude width
    localparam int CIW = 3;                // config index width

    // candidate depth per encoder
    localparam int NCELL = 64;
    localparam int CW    = $clog2(NCELL);
    localparam int MCW   = $clog2(MW);

    localparam logic [8:0] DEG360 = 9'd360;

    typedef logic signed [PW-1:0] pos_t;

    // one beat moving down the cell chain
    typedef struct packed {
        logic v;
        logic hit;
        pos_t pos;
    } beat_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_BASE,
        ST_GO1,
        ST_WAIT1,
        ST_GO2,
        ST_WAIT2,
        ST_LOAD,
        ST_SCAN,
        ST_FIN
    } state_t;

    typedef enum logic [CIW-1:0] {
        REG_RECIP1  = 3'd0,
        REG_RECIP2  = 3'd1,
        REG_REVERSE = 3'd2,
        REG_ZERO1   = 3'd3,
        REG_ZERO2   = 3'd4,
        REG_WLOW    = 3'd5,
        REG_WHIGH   = 3'd6,
        REG_TOL     = 3'd7
    } cfg_idx_t;

endpackage

/* hw/rtl/devr_if.sv */
`timescale 1ns / 1ps
interface devr_in_if;
    logic                         valid;
    logic                         ready;
    logic [devr_pkg::RDW-1:0]     enc1_reading;
    logic [devr_pkg::RDW-1:0]     enc2_reading;
    modport source (output valid, enc1_reading, enc2_reading, input ready);
    modport sink   (input valid, enc1_reading, enc2_reading, output ready);
endinterface

interface devr_out_if;
    logic                         valid;
    logic                         ready;
    logic signed [devr_pkg::OW-1:0] abs_position;
    logic                         found;
    modport source (output valid, abs_position, found, input ready);
    modport sink   (input valid, abs_position, found, output ready);
endinterface

interface devr_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [devr_pkg::CIW-1:0]     index;
    logic [devr_pkg::OW-1:0]      data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* hw/rtl/devr_rem.sv */
`timescale 1ns / 1ps
module devr_rem (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [devr_pkg::MW-1:0]  dividend,
    input  logic [devr_pkg::SW-1:0]  divisor,
    output logic                     done,
    output logic [devr_pkg::SW-1:0]  rem
);

    logic [devr_pkg::MW-1:0]  dvd_reg;
    logic [devr_pkg::SW-1:0]  rem_reg;
    logic [devr_pkg::SW-1:0]  div_reg;
    logic [devr_pkg::MCW-1:0] cnt_reg;
    logic                     busy_reg;
    logic                     done_reg;
    logic [devr_pkg::SW:0]    trial;
    logic [devr_pkg::SW:0]    diff;

    // restoring remainder, one dividend bit a cycle
    assign trial = {rem_reg, dvd_reg[devr_pkg::MW-1]};
    assign diff  = trial - {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == devr_pkg::MCW'(devr_pkg::MW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            div_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[devr_pkg::MW-2:0], 1'b0};
            rem_reg <= diff[devr_pkg::SW] ? trial[devr_pkg::SW-1:0] : diff[devr_pkg::SW-1:0];
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

/* hw/rtl/devr_cell.sv */
`timescale 1ns / 1ps
module devr_cell (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      load,
    input  devr_pkg::pos_t            c2_in,
    input  logic                      c2v_in,
    output devr_pkg::pos_t            c2_out,
    output logic                      c2v_out,
    input  logic [devr_pkg::RDW-1:0]  tol,
    input  devr_pkg::beat_t           beat_in,
    output devr_pkg::beat_t           beat_out
);

    devr_pkg::pos_t  c2_reg;
    logic            c2v_reg;
    devr_pkg::beat_t beat_reg;
    devr_pkg::beat_t beat_next;
    devr_pkg::pos_t  delta;
    devr_pkg::pos_t  tol_pos;
    logic            match;

    assign tol_pos = devr_pkg::pos_t'({{(devr_pkg::PW - devr_pkg::RDW){1'b0}}, tol});
    assign delta   = beat_in.pos - c2_reg;
    assign match   = beat_in.v && c2v_reg && (delta < tol_pos) && (delta > -tol_pos);

    always_comb
    begin
        beat_next     = beat_in;
        beat_next.hit = beat_in.hit | match;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c2_reg   <= '0;
            c2v_reg  <= 1'b0;
            beat_reg <= '0;
        end
        else
        begin
            if (load)
            begin
                c2_reg  <= c2_in;
                c2v_reg <= c2v_in;
            end
            beat_reg <= beat_next;
        end
    end

    assign c2_out   = c2_reg;
    assign c2v_out  = c2v_reg;
    assign beat_out = beat_reg;

endmodule

/* hw/rtl/dual_encoder_vernier_resolver.sv */
`timescale 1ns / 1ps
// Dual-encoder vernier resolver.
// in_ch carries one beat per sample: enc1_reading and enc2_reading, Q9.16
// degrees. out_ch returns one beat per sample: abs_position (signed Q31.16)
// and found; abs_position is zero when found is low.
// cfg takes register writes (index 0..7, data in the low bits) at any time;
// write only while no sample is in flight.
// Flow of one sample: the base products and steps (MUL, BASE), two runs
// of the shared remainder unit that place the lowest candidate of each
// encoder in the window, a load of the NCELL encoder-2 candidates into
// the cell row (LOAD), then a scan (SCAN) in which the encoder-1
// candidates stream through the row and are checked in every cell.
// One sample is in work at a time. A zero reciprocal skips the search
// and reports not found.
// Reset returns the configuration and control registers to their defaults
// The result sits in an output register; in_ch takes the next sample while
// it waits, and a new result holds in FIN until the receiver takes the old.
module dual_encoder_vernier_resolver (
    input  logic         clk,
    input  logic         rst_n,
    devr_in_if.sink      in_ch,
    devr_out_if.source   out_ch,
    devr_cfg_if.sink     cfg
);

    // configuration registers
    logic [devr_pkg::RCW-1:0]       recip1_reg;
    logic [devr_pkg::RCW-1:0]       recip2_reg;
    logic [1:0]                     rev_reg;
    logic [devr_pkg::RDW-1:0]       zero1_reg;
    logic [devr_pkg::RDW-1:0]       zero2_reg;
    logic signed [devr_pkg::OW-1:0] wlow_reg;
    logic signed [devr_pkg::OW-1:0] whigh_reg;
    logic [devr_pkg::RDW-1:0]       tol_reg;

    devr_pkg::state_t state_reg;
    devr_pkg::state_t state_next;

    logic [devr_pkg::RDW-1:0] rd1_reg;
    logic [devr_pkg::RDW-1:0] rd2_reg;
    logic [devr_pkg::PRW-1:0] prod1_reg;
    logic [devr_pkg::PRW-1:0] prod2_reg;
    logic                     neg1_reg;
    logic                     neg2_reg;
    logic [devr_pkg::SW-1:0]  step1_reg;
    logic [devr_pkg::SW-1:0]  step2_reg;
    devr_pkg::pos_t           a1_reg;
    devr_pkg::pos_t           a2_reg;
    devr_pkg::pos_t           acc1_reg;
    devr_pkg::pos_t           acc2_reg;
    logic [devr_pkg::CW:0]    cnt_reg;
    logic                     found_reg;
    devr_pkg::pos_t           pos_reg;

    logic                     out_valid_reg;
    logic signed [devr_pkg::OW-1:0] out_pos_reg;
    logic                     out_found_reg;

    logic in_take;
    logic cfg_take;
    logic out_load;
    logic skip;
    logic load_en;

    devr_pkg::pos_t wlow_ext;
    devr_pkg::pos_t whigh_ext;

    assign wlow_ext  = devr_pkg::pos_t'({{(devr_pkg::PW - devr_pkg::OW){wlow_reg[devr_pkg::OW-1]}},
                                         wlow_reg});
    assign whigh_ext = devr_pkg::pos_t'({{(devr_pkg::PW - devr_pkg::OW){whigh_reg[devr_pkg::OW-1]}},
                                         whigh_reg});

    assign in_ch.ready = (state_reg == devr_pkg::ST_IDLE);
    assign in_take     = in_ch.valid && in_ch.ready;
    assign cfg.ready   = 1'b1;
    assign cfg_take    = cfg.valid;
    assign skip        = (recip1_reg == '0) || (recip2_reg == '0);
    assign load_en     = (state_reg == devr_pkg::ST_LOAD);

    //------------------------------------------------------------------
    // configuration
    //------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            recip1_reg <= devr_pkg::RCW'(32'h0100_0000);
            recip2_reg <= devr_pkg::RCW'(32'h0100_0000);
            rev_reg    <= 2'b00;
            zero1_reg  <= '0;
            zero2_reg  <= '0;
            wlow_reg   <= '0;
            whigh_reg  <= devr_pkg::OW'(48'd23592960);
            tol_reg    <= devr_pkg::RDW'(25'd65536);
        end
        else if (cfg_take)
        begin
            case (devr_pkg::cfg_idx_t'(cfg.index))
                devr_pkg::REG_RECIP1:  recip1_reg <= cfg.data[devr_pkg::RCW-1:0];
                devr_pkg::REG_RECIP2:  recip2_reg <= cfg.data[devr_pkg::RCW-1:0];
                devr_pkg::REG_REVERSE: rev_reg    <= cfg.data[1:0];
                devr_pkg::REG_ZERO1:   zero1_reg  <= cfg.data[devr_pkg::RDW-1:0];
                devr_pkg::REG_ZERO2:   zero2_reg  <= cfg.data[devr_pkg::RDW-1:0];
                devr_pkg::REG_WLOW:    wlow_reg   <= cfg.data;
                devr_pkg::REG_WHIGH:   whigh_reg  <= cfg.data;
                devr_pkg::REG_TOL:     tol_reg    <= cfg.data[devr_pkg::RDW-1:0];
                default:               ;
            endcase
        end
    end

    //------------------------------------------------------------------
    // base products and steps
    //------------------------------------------------------------------
    function automatic logic [40:0] DEG360_MUL(input logic [devr_pkg::RCW-1:0] r);
        DEG360_MUL = 41'(r) * 41'(devr_pkg::DEG360);
    endfunction

    logic signed [devr_pkg::RDW:0] diff1;
    logic signed [devr_pkg::RDW:0] diff2;
    logic [devr_pkg::RDW:0]        mag1;
    logic [devr_pkg::RDW:0]        mag2;
    logic [40:0]                   sraw1;
    logic [40:0]                   sraw2;

    assign diff1 = $signed({1'b0, rd1_reg}) - $signed({1'b0, zero1_reg});
    assign diff2 = $signed({1'b0, rd2_reg}) - $signed({1'b0, zero2_reg});
    assign mag1  = diff1[devr_pkg::RDW] ? -diff1 : diff1;
    assign mag2  = diff2[devr_pkg::RDW] ? -diff2 : diff2;
    assign sraw1 = 41'(DEG360_MUL(recip1_reg)) + 41'd128;
    assign sraw2 = 41'(DEG360_MUL(recip2_reg)) + 41'd128;

    // round half away from zero, then apply the sign
    logic [devr_pkg::PRW:0] rnd1;
    logic [devr_pkg::PRW:0] rnd2;
    devr_pkg::pos_t         r1;
    devr_pkg::pos_t         r2;
    devr_pkg::pos_t         b1;
    devr_pkg::pos_t         b2;

    assign rnd1 = {1'b0, prod1_reg} + (devr_pkg::PRW+1)'(1 << 23);
    assign rnd2 = {1'b0, prod2_reg} + (devr_pkg::PRW+1)'(1 << 23);
    assign r1   = devr_pkg::pos_t'({{(devr_pkg::PW - devr_pkg::RW){1'b0}}, rnd1[devr_pkg::PRW:24]});
    assign r2   = devr_pkg::pos_t'({{(devr_pkg::PW - devr_pkg::RW){1'b0}}, rnd2[devr_pkg::PRW:24]});
    assign b1   = neg1_reg ? -r1 : r1;
    assign b2   = neg2_reg ? -r2 : r2;

    //------------------------------------------------------------------
    // remainder unit: offset of the lowest candidate above window_low
    //------------------------------------------------------------------
    logic                     rem_start;
    logic                     rem_done;
    logic [devr_pkg::SW-1:0]  rem_val;
    devr_pkg::pos_t           a_sel;
    devr_pkg::pos_t           a_mag;
    logic [devr_pkg::SW-1:0]  s_sel;
    devr_pkg::pos_t           off;
    devr_pkg::pos_t           first_cand;

    assign a_sel     = (state_reg == devr_pkg::ST_GO1 || state_reg == devr_pkg::ST_WAIT1)
                       ? a1_reg : a2_reg;
    assign s_sel     = (state_reg == devr_pkg::ST_GO1 || state_reg == devr_pkg::ST_WAIT1)
                       ? step1_reg : step2_reg;
    assign a_mag     = a_sel[devr_pkg::PW-1] ? -a_sel : a_sel;
    assign rem_start = (state_reg == devr_pkg::ST_GO1) || (state_reg == devr_pkg::ST_GO2);

    devr_rem u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (rem_start),
        .dividend (a_mag[devr_pkg::MW-1:0]),
        .divisor  (s_sel),
        .done     (rem_done),
        .rem      (rem_val)
    );

    // negative distance: truncating division leaves |a| mod step to go up;
    // positive distance: round up to the next step unless exact
    always_comb
    begin
        if (a_sel[devr_pkg::PW-1])
        begin
            off = devr_pkg::pos_t'({{(devr_pkg::PW - devr_pkg::SW){1'b0}}, rem_val});
        end
        else if (rem_val == '0)
        begin
            off = '0;
        end
        else
        begin
            off = devr_pkg::pos_t'({{(devr_pkg::PW - devr_pkg::SW){1'b0}}, s_sel - rem_val});
        end
    end
    assign first_cand = wlow_ext + off;

    //------------------------------------------------------------------
    // cell row
    //------------------------------------------------------------------
    devr_pkg::pos_t  c2_chain   [devr_pkg::NCELL+1];
    logic            c2v_chain  [devr_pkg::NCELL+1];
    devr_pkg::beat_t beat_chain [devr_pkg::NCELL+1];
    devr_pkg::beat_t tail;

    assign c2_chain[0]       = acc2_reg;
    assign c2v_chain[0]      = (acc2_reg <= whigh_ext);
    assign beat_chain[0].v   = (state_reg == devr_pkg::ST_SCAN)
                               && (cnt_reg < (devr_pkg::CW+1)'(devr_pkg::NCELL))
                               && (acc1_reg <= whigh_ext);
    assign beat_chain[0].hit = 1'b0;
    assign beat_chain[0].pos = acc1_reg;

    for (genvar k = 0; k < devr_pkg::NCELL; k++)
    begin : g_cell
        devr_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .load     (load_en),
            .c2_in    (c2_chain[k]),
            .c2v_in   (c2v_chain[k]),
            .c2_out   (c2_chain[k+1]),
            .c2v_out  (c2v_chain[k+1]),
            .tol      (tol_reg),
            .beat_in  (beat_chain[k]),
            .beat_out (beat_chain[k+1])
        );
    end

    assign tail = beat_chain[devr_pkg::NCELL];

    //------------------------------------------------------------------
    // sequencer
    //------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= devr_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        out_load   = 1'b0;
        case (state_reg)
            devr_pkg::ST_IDLE:
            begin
                if (in_take)
                begin
                    state_next = devr_pkg::ST_MUL;
                end
            end
            devr_pkg::ST_MUL:   state_next = devr_pkg::ST_BASE;
            devr_pkg::ST_BASE:  state_next = skip ? devr_pkg::ST_FIN : devr_pkg::ST_GO1;
            devr_pkg::ST_GO1:   state_next = devr_pkg::ST_WAIT1;
            devr_pkg::ST_WAIT1:
            begin
                if (rem_done)
                begin
                    state_next = devr_pkg::ST_GO2;
                end
            end
            devr_pkg::ST_GO2:   state_next = devr_pkg::ST_WAIT2;
            devr_pkg::ST_WAIT2:
            begin
                if (rem_done)
                begin
                    state_next = devr_pkg::ST_LOAD;
                end
            end
            devr_pkg::ST_LOAD:
            begin
                if (cnt_reg == (devr_pkg::CW+1)'(devr_pkg::NCELL - 1))
                begin
                    state_next = devr_pkg::ST_SCAN;
                end
            end
            devr_pkg::ST_SCAN:
            begin
                if (cnt_reg == (devr_pkg::CW+1)'(2 * devr_pkg::NCELL - 1))
                begin
                    state_next = devr_pkg::ST_FIN;
                end
            end
            devr_pkg::ST_FIN:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_load   = 1'b1;
                    state_next = devr_pkg::ST_IDLE;
                end
            end
            default:            state_next = devr_pkg::ST_IDLE;
        endcase
    end

    // datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                devr_pkg::ST_IDLE:
                begin
                    found_reg <= 1'b0;
                    cnt_reg   <= '0;
                end
                devr_pkg::ST_LOAD:
                begin
                    cnt_reg <= (cnt_reg == (devr_pkg::CW+1)'(devr_pkg::NCELL - 1))
                               ? '0 : cnt_reg + 1'b1;
                end
                devr_pkg::ST_SCAN:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    // first hit at the tail is the lowest matching candidate
                    if (tail.v && tail.hit && !found_reg)
                    begin
                        found_reg <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            devr_pkg::ST_IDLE:
            begin
                if (in_take)
                begin
                    rd1_reg <= in_ch.enc1_reading;
                    rd2_reg <= in_ch.enc2_reading;
                end
                pos_reg <= '0;
            end
            devr_pkg::ST_MUL:
            begin
                prod1_reg <= devr_pkg::PRW'(mag1[devr_pkg::RDW-1:0]) * devr_pkg::PRW'(recip1_reg);
                prod2_reg <= devr_pkg::PRW'(mag2[devr_pkg::RDW-1:0]) * devr_pkg::PRW'(recip2_reg);
                neg1_reg  <= diff1[devr_pkg::RDW] ^ rev_reg[0];
                neg2_reg  <= diff2[devr_pkg::RDW] ^ rev_reg[1];
                step1_reg <= sraw1[40:8];
                step2_reg <= sraw2[40:8];
            end
            devr_pkg::ST_BASE:
            begin
                a1_reg <= wlow_ext - b1;
                a2_reg <= wlow_ext - b2;
            end
            devr_pkg::ST_WAIT1:
            begin
                if (rem_done)
                begin
                    acc1_reg <= first_cand;
                end
            end
            devr_pkg::ST_WAIT2:
            begin
                if (rem_done)
                begin
                    acc2_reg <= first_cand;
                end
            end
            devr_pkg::ST_LOAD:
            begin
                // advance encoder-2 candidates into the row
                acc2_reg <= acc2_reg + devr_pkg::pos_t'({{(devr_pkg::PW - devr_pkg::SW){1'b0}},
                                                        step2_reg});
            end
            devr_pkg::ST_SCAN:
            begin
                acc1_reg <= acc1_reg + devr_pkg::pos_t'({{(devr_pkg::PW - devr_pkg::SW){1'b0}},
                                                        step1_reg});
                if (tail.v && tail.hit && !found_reg)
                begin
                    pos_reg <= tail.pos;
                end
            end
            default: ;
        endcase
    end

    //------------------------------------------------------------------
    // output register
    //------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_found_reg <= found_reg;
            out_pos_reg   <= found_reg ? pos_reg[devr_pkg::OW-1:0] : '0;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.abs_position = out_pos_reg;
    assign out_ch.found        = out_found_reg;

    //------------------------------------------------------------------
    // checks
    //------------------------------------------------------------------
    a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.found |-> out_ch.abs_position == '0)
        else $error("not-found beat carries a nonzero position");

    a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> !in_ch.ready)
        else $error("second sample taken while one is in work");

    a_rem_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        rem_done |-> (state_reg == devr_pkg::ST_WAIT1 || state_reg == devr_pkg::ST_WAIT2))
        else $error("remainder finished outside a wait state");

    a_found_scan: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(found_reg) |-> $past(state_reg) == devr_pkg::ST_SCAN)
        else $error("match flagged outside the scan");

endmodule

/* tb/dual_encoder_vernier_resolver_checker.sv */
`timescale 1ns / 1ps
module dual_encoder_vernier_resolver_checker
    import devr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    devr_in_if   in_ch,
    devr_out_if  out_ch,
    devr_cfg_if  cfg,
    output int   errors,
    output int   pending
);

    typedef struct {
        logic signed [OW-1:0] pos;
        logic                 found;
    } position_t;

    logic [RCW-1:0]       recip1, recip2;
    logic [1:0]           rev_bits;
    logic [RDW-1:0]       zero1, zero2, tol;
    logic signed [OW-1:0] win_lo, win_hi;

    position_t resolved_q[$];

    function automatic longint scaled_base(logic [RDW-1:0] reading, logic [RDW-1:0] zero,
                                           logic [RCW-1:0] recip, logic rev);
        longint          diff;
        logic            neg;
        longint unsigned mag;
        longint          r;
        diff = longint'(reading) - longint'(zero);
        neg  = diff < 0;
        mag  = longint'(neg ? -diff : diff) * longint'(recip);
        r    = longint'((mag + 64'd8388608) >> 24);
        return (neg != rev) ? -r : r;
    endfunction

    function automatic longint turn_step(logic [RCW-1:0] recip);
        longint unsigned s;
        s = (64'd360 * longint'(recip) + 64'd128) >> 8;
        return longint'(s);
    endfunction

    // lowest candidates of one encoder inside the window, ascending
    function automatic int window_candidates(longint base, longint step,
                                             output longint list[NCELL]);
        int     n;
        longint lo, hi, a, q, c;
        n  = 0;
        lo = longint'(win_lo);
        hi = longint'(win_hi);
        for (int i = 0; i < NCELL; i++)
            list[i] = 0;
        if (lo > hi)
            return 0;
        a = lo - base;
        q = a / step;
        if ((a % step) != 0 && a > 0)
            q++;
        c = base + q * step;
        while (n < NCELL && c <= hi)
        begin
            list[n] = c;
            n++;
            c += step;
        end
        return n;
    endfunction

    function automatic position_t resolve(logic [RDW-1:0] r1, logic [RDW-1:0] r2);
        position_t res;
        longint    c1[NCELL];
        longint    c2[NCELL];
        int        n1, n2;
        longint    d;
        res.pos   = '0;
        res.found = 1'b0;
        if (recip1 == 0 || recip2 == 0)
            return res;
        n1 = window_candidates(scaled_base(r1, zero1, recip1, rev_bits[0]),
                               turn_step(recip1), c1);
        n2 = window_candidates(scaled_base(r2, zero2, recip2, rev_bits[1]),
                               turn_step(recip2), c2);
        for (int i = 0; i < n1; i++)
            for (int j = 0; j < n2; j++)
            begin
                d = c1[i] - c2[j];
                if (d < 0)
                    d = -d;
                if (d < longint'(tol) && !res.found)
                begin
                    res.pos   = c1[i][OW-1:0];
                    res.found = 1'b1;
                end
            end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        position_t want;
        if (!rst_n)
        begin
            recip1   = 32'h0100_0000;
            recip2   = 32'h0100_0000;
            rev_bits = '0;
            zero1    = '0;
            zero2    = '0;
            win_lo   = '0;
            win_hi   = 48'd23592960;
            tol      = 25'd65536;
            resolved_q.delete();
            errors   = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg_idx_t'(cfg.index))
                    REG_RECIP1:  recip1   = cfg.data[RCW-1:0];
                    REG_RECIP2:  recip2   = cfg.data[RCW-1:0];
                    REG_REVERSE: rev_bits = cfg.data[1:0];
                    REG_ZERO1:   zero1    = cfg.data[RDW-1:0];
                    REG_ZERO2:   zero2    = cfg.data[RDW-1:0];
                    REG_WLOW:    win_lo   = cfg.data;
                    REG_WHIGH:   win_hi   = cfg.data;
                    REG_TOL:     tol      = cfg.data[RDW-1:0];
                    default: ;
                endcase
            end
            if (in_ch.valid && in_ch.ready)
                resolved_q.insert(resolved_q.size(),
                                  resolve(in_ch.enc1_reading, in_ch.enc2_reading));
            if (out_ch.valid && out_ch.ready)
            begin
                if (resolved_q.size() == 0)
                begin
                    $error("unexpected result beat: abs_position %0d found %0b",
                           out_ch.abs_position, out_ch.found);
                    errors++;
                end
                else
                begin
                    want = resolved_q.pop_front();
                    if (out_ch.found !== want.found)
                    begin
                        $error("found: expected %0b actual %0b", want.found, out_ch.found);
                        errors++;
                    end
                    if (out_ch.abs_position !== want.pos)
                    begin
                        $error("abs_position: expected %0d actual %0d",
                               want.pos, out_ch.abs_position);
                        errors++;
                    end
                end
            end
        end
        pending = resolved_q.size();
    end

endmodule

/* tb/dual_encoder_vernier_resolver_tb.sv */
`timescale 1ns / 1ps
module dual_encoder_vernier_resolver_tb;
    import devr_pkg::*;

    localparam int       FULL_TURN = 23592960;    // 360 degrees in Q.16
    localparam int       READ_MAX  = FULL_TURN - 1;
    localparam int       ONE_DEG   = 65536;
    localparam int       HOLD_LEN  = 3000;

    logic clk;
    logic rst_n;

    devr_in_if  in_ch ();
    devr_out_if out_ch ();
    devr_cfg_if cfg ();

    int errors;
    int pending;

    // traffic shaping, set per phase by the stimulus
    int idle_pct;
    int stall_pct;
    bit hold_req;
    bit hold_seen;
    int hold_left;

    dual_encoder_vernier_resolver dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg    (cfg)
    );

    dual_encoder_vernier_resolver_checker checker_i (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .cfg     (cfg),
        .errors  (errors),
        .pending (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #20_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // Receiver: random stalls, plus one long hold-off counted here so the
    // sender keeps pushing into a full pipeline.
    always @(posedge clk)
    begin
        if (hold_req && !hold_seen)
            hold_left = HOLD_LEN;
        hold_seen = hold_req;
        if (hold_left > 0)
        begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    // Offer one sample; wait for the beat to be taken, then maybe go idle.
    task automatic send_sample(logic [RDW-1:0] r1, logic [RDW-1:0] r2);
        bit taken;
        int gap;
        in_ch.valid        <= 1'b1;
        in_ch.enc1_reading <= r1;
        in_ch.enc2_reading <= r2;
        // ready is sampled at the falling edge, where it is stable
        do
        begin
            @(negedge clk);
            taken = in_ch.ready;
            @(posedge clk);
        end
        while (!taken);
        if ($urandom_range(99) < idle_pct)
        begin
            gap = $urandom_range(1, 6);
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [OW-1:0] value);
        bit taken;
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        do
        begin
            @(negedge clk);
            taken = cfg.ready;
            @(posedge clk);
        end
        while (!taken);
        cfg.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Drop valid and wait until every result is back.
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic apply_setup(logic [RCW-1:0] rc1, logic [RCW-1:0] rc2, logic [1:0] rev,
                               logic [RDW-1:0] z1, logic [RDW-1:0] z2,
                               longint lo, longint hi, logic [RDW-1:0] tl);
        drain();
        write_reg(REG_RECIP1, OW'(rc1));
        write_reg(REG_RECIP2, OW'(rc2));
        write_reg(REG_REVERSE, OW'(rev));
        write_reg(REG_ZERO1, OW'(z1));
        write_reg(REG_ZERO2, OW'(z2));
        write_reg(REG_WLOW, lo[OW-1:0]);
        write_reg(REG_WHIGH, hi[OW-1:0]);
        write_reg(REG_TOL, OW'(tl));
    endtask

    function automatic logic [RDW-1:0] any_reading();
        // lean on the ends of the range now and then
        case ($urandom_range(9))
            0: return '0;
            1: return RDW'(READ_MAX);
            default: return RDW'($urandom_range(0, READ_MAX));
        endcase
    endfunction

    // Gear pair 1:2 - a true position P gives readings whose candidates meet
    // at P; add a little jitter, sometimes more than the tolerance.
    task automatic send_geared(logic [RDW-1:0] z1, logic [RDW-1:0] z2);
        longint p, r1, r2, jit;
        if ($urandom_range(99) < 15)
        begin
            send_sample(any_reading(), any_reading());
            return;
        end
        p   = $urandom_range(0, 2 * FULL_TURN - 1);
        jit = longint'($urandom_range(0, 2 * ONE_DEG)) - ONE_DEG;
        r1  = (p % FULL_TURN + z1) % FULL_TURN;
        r2  = (2 * p + z2 + jit + FULL_TURN) % FULL_TURN;
        send_sample(RDW'(r1), RDW'(r2));
    endtask

    task automatic set_traffic(int phase);
        case (phase % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 47; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 47; end
            default: begin idle_pct = 33; stall_pct = 33; end
        endcase
    endtask

    initial
    begin
        logic [RDW-1:0] z1, z2;
        logic [RCW-1:0] rc1, rc2;
        longint         lo, span;

        rst_n              = 1'b0;
        in_ch.valid        = 1'b0;
        in_ch.enc1_reading = '0;
        in_ch.enc2_reading = '0;
        cfg.valid          = 1'b0;
        cfg.index          = '0;
        cfg.data           = '0;
        out_ch.ready       = 1'b0;
        idle_pct           = 0;
        stall_pct          = 0;
        hold_req           = 1'b0;
        hold_seen          = 1'b0;
        hold_left          = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // ---- directed: reset defaults, reading extremes ----
        send_sample('0, '0);
        send_sample(RDW'(READ_MAX), RDW'(READ_MAX));
        send_sample('0, RDW'(READ_MAX));
        send_sample(RDW'(READ_MAX), '0);
        send_sample(RDW'(180 * ONE_DEG), RDW'(180 * ONE_DEG) + RDW'(ONE_DEG - 1));
        send_sample(RDW'(90 * ONE_DEG), RDW'(91 * ONE_DEG));

        // zero reciprocal on either encoder skips the search
        apply_setup(32'd0, 32'h0100_0000, 2'd0, '0, '0, 0, FULL_TURN, RDW'(ONE_DEG));
        send_sample('0, '0);
        send_sample(RDW'(READ_MAX), '0);
        apply_setup(32'h0100_0000, 32'd0, 2'd3, '0, '0, 0, FULL_TURN, RDW'(ONE_DEG));
        send_sample('0, '0);

        // empty window: low above high
        apply_setup(32'h0100_0000, 32'h0100_0000, 2'd0, '0, '0, FULL_TURN, 0, RDW'(ONE_DEG));
        send_sample('0, '0);
        send_sample(RDW'(ONE_DEG), RDW'(ONE_DEG));

        // zero tolerance never matches
        apply_setup(32'h0100_0000, 32'h0080_0000, 2'd0, '0, '0, 0, 2 * FULL_TURN, '0);
        send_sample('0, '0);
        send_sample(RDW'(ONE_DEG), RDW'(2 * ONE_DEG));

        // one-LSB steps: far more candidates than the row holds
        apply_setup(32'd1, 32'd1, 2'd2, RDW'(READ_MAX), RDW'(READ_MAX), 0, 1000, RDW'(2));
        send_sample('0, RDW'(READ_MAX));
        send_sample(RDW'(READ_MAX), '0);

        // widest window, largest reciprocals, a full-turn tolerance, encoder-1 offset at max
        apply_setup(32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'd1, RDW'(READ_MAX), '0,
                    -(64'sd1 <<< 47), (64'sd1 <<< 47) - 1, RDW'(FULL_TURN));
        send_sample(RDW'(READ_MAX), RDW'(READ_MAX));
        send_sample('0, RDW'(12345));
        send_sample(RDW'(ONE_DEG), '0);

        // reversed both, negative window
        apply_setup(32'h0100_0000, 32'h0200_0000, 2'd3, RDW'(ONE_DEG), RDW'(ONE_DEG),
                    -2 * FULL_TURN, 0, RDW'(ONE_DEG));
        send_sample(RDW'(ONE_DEG), RDW'(ONE_DEG));
        send_sample('0, RDW'(READ_MAX));

        // ---- random: geared pairs with random content ----
        for (int ph = 0; ph < 3; ph++)
        begin
            z1 = RDW'($urandom_range(0, READ_MAX));
            z2 = RDW'($urandom_range(0, READ_MAX));
            apply_setup(32'h0100_0000, 32'h0080_0000, 2'd0, z1, z2, 0, 2 * FULL_TURN - 1,
                        RDW'($urandom_range(1, 3 * ONE_DEG)));
            set_traffic(ph);
            for (int n = 0; n < 90; n++)
            begin
                // long receiver hold-off once while the sender keeps offering
                if (ph == 0 && n == 10)
                    hold_req <= 1'b1;
                send_geared(z1, z2);
            end
            hold_req <= 1'b0;
        end

        // ---- random: arbitrary settings ----
        for (int ph = 0; ph < 4; ph++)
        begin
            rc1  = ($urandom_range(19) == 0) ? 32'd0 : RCW'($urandom >> $urandom_range(0, 12));
            rc2  = ($urandom_range(19) == 0) ? 32'd0 : RCW'($urandom >> $urandom_range(0, 12));
            lo   = longint'($urandom_range(0, 8 * FULL_TURN)) - 4 * FULL_TURN;
            span = ($urandom_range(9) == 0) ? -longint'($urandom_range(1, ONE_DEG))
                                            : longint'($urandom_range(0, 16 * FULL_TURN));
            if (ph == 3)
            begin
                // the window ends with bits high all the way up
                lo   = -(64'sd1 <<< 47);
                span = (64'sd1 <<< 48) - 1;
            end
            apply_setup(rc1, rc2, 2'($urandom_range(0, 3)), RDW'($urandom_range(0, READ_MAX)),
                        RDW'($urandom_range(0, READ_MAX)), lo, lo + span,
                        RDW'($urandom_range(0, FULL_TURN)));
            set_traffic(ph + 1);
            for (int n = 0; n < 45; n++)
                send_sample(any_reading(), any_reading());
        end

        drain();
        repeat (400) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
